[src/scmap_pkg.sv]
`timescale 1ns / 1ps
// Package for the scalar to RGBA color map core: payload types, map codes,
// fixed-point constants and the status base-color table. No dependencies.
package scmap_pkg;

    // Input scalar width (Q4.12 at 16 bits) and derived internal widths.
    localparam int VALUE_W = 16;
    localparam int FRAC_W  = 12;
    localparam int ONE_Q   = 1 << FRAC_W;
    localparam int CLAMP_W = FRAC_W + 1;          // holds 0 .. ONE_Q
    localparam int FS_W    = FRAC_W + 2;          // holds 0 .. 2*ONE_Q
    localparam int WIDE_W  = 34;                  // signed compare width
    localparam int CH_W    = 8;
    localparam int SEL_W   = 4;

    // 1/pi in Q16 for the phase map.
    localparam int INV_PI_Q16 = 20861;
    localparam int INV_PI_W   = 15;
    localparam int PROD_W     = VALUE_W + INV_PI_W;

    // Status map thresholds, exact against 0.3, 1.2 and 0.95.
    localparam int STAT_RED_LIM    = (3 * ONE_Q + 9) / 10;    // v < 0.3
    localparam int STAT_ORANGE_LIM = (12 * ONE_Q + 9) / 10;   // v >= 1.2
    localparam int STAT_BLEND_LIM  = (19 * ONE_Q) / 20 + 1;   // v > 0.95

    // Status blend: c = (255*(b*6*ONE_Q + n*(10-b)) + 30*ONE_Q) / (60*ONE_Q).
    // Status ramp:  c = (255*b*n + 35*ONE_Q) / (70*ONE_Q).
    localparam int BLEND_OFS   = 95 * ONE_Q;
    localparam int RAMP_OFS    = 3 * ONE_Q;
    localparam int BLEND_SCALE = 6 * ONE_Q;
    localparam int BLEND_ROUND = 30 * ONE_Q;
    localparam int RAMP_ROUND  = 35 * ONE_Q;
    localparam int STAT_N_W    = 15;
    localparam int STAT_NUM_W  = 27;
    localparam int STAT_Q_W    = 14;
    // 60*ONE_Q = 15 * 2^(FRAC_W+2), 70*ONE_Q = 35 * 2^(FRAC_W+1).
    localparam int BLEND_SHIFT = FRAC_W + 2;
    localparam int RAMP_SHIFT  = FRAC_W + 1;
    // Reciprocals that give an exact floor over the quotient range in use.
    localparam int RECIP15       = 4370;
    localparam int RECIP15_SHIFT = 16;
    localparam int RECIP35       = 7490;
    localparam int RECIP35_SHIFT = 18;
    localparam int RECIP_W       = 13;

    // Map codes held in map_select; codes above the status maps act as grey.
    localparam logic [SEL_W-1:0] MAP_GREY          = 4'd0;
    localparam logic [SEL_W-1:0] MAP_GREY_FS       = 4'd1;
    localparam logic [SEL_W-1:0] MAP_RED           = 4'd2;
    localparam logic [SEL_W-1:0] MAP_GREEN         = 4'd3;
    localparam logic [SEL_W-1:0] MAP_BLUE          = 4'd4;
    localparam logic [SEL_W-1:0] MAP_RAINBOW       = 4'd5;
    localparam logic [SEL_W-1:0] MAP_RAINBOW_FS    = 4'd6;
    localparam logic [SEL_W-1:0] MAP_PHASE         = 4'd7;
    localparam logic [SEL_W-1:0] MAP_STATUS_BLUE   = 4'd8;
    localparam logic [SEL_W-1:0] MAP_STATUS_CYAN   = 4'd9;
    localparam logic [SEL_W-1:0] MAP_STATUS_PURPLE = 4'd10;
    localparam logic [SEL_W-1:0] MAP_STATUS_GREEN  = 4'd11;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_MAP_SELECT = 1'b0;   // register index, paddr[2]

    // Fixed channel values.
    localparam logic [CH_W-1:0] CH_FULL    = 8'd255;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'd0;
    localparam logic [CH_W-1:0] CH_ORANGE  = 8'd128;
    localparam logic [CH_W-1:0] CH_INVALID = 8'd204;
    localparam logic [CH_W-1:0] ALPHA_INV  = 8'd102;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      value_not_finite;
    } sample_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } color_t;

    // Base colors of the status maps, in tenths: channel 0 red, 1 green, 2 blue.
    function automatic logic [3:0] status_base(input logic [1:0] map_idx,
                                               input logic [1:0] ch);
        logic [3:0] b;
        b = 4'd0;
        case (map_idx)
            2'd0: b = (ch == 2'd2) ? 4'd10 : 4'd0;
            2'd1: b = (ch == 2'd0) ? 4'd0 : 4'd10;
            2'd2: b = (ch == 2'd1) ? 4'd0 : 4'd7;
            default: b = (ch == 2'd1) ? 4'd10 : 4'd0;
        endcase
        return b;
    endfunction

endpackage

[src/scalar_to_rgba_color_map_core.sv]
`timescale 1ns / 1ps
// An accepted sample transaction passes the five register stages in order to color_valid.
// Throughput: one sample per clock while color_stall is low; the stages (input,
// clamp and 1/pi multiply, linear scale and status numerator, reciprocal divide
// and hue fraction, final select) each pass one transaction per cycle unless stalled.
// Reset clears every stage valid bit and sets map_select to grey (0).
// Scalar to RGBA color map core; depends on scmap_pkg.
module scalar_to_rgba_color_map_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  scmap_pkg::sample_t                sample,
    output logic                              color_valid,
    input  logic                              color_stall,
    output scmap_pkg::color_t                 color,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scmap_pkg::APB_AW-1:0]      paddr,
    input  logic [scmap_pkg::APB_DW-1:0]      pwdata,
    output logic [scmap_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    localparam int VW  = scmap_pkg::VALUE_W;
    localparam int WW  = scmap_pkg::WIDE_W;
    localparam int CLW = scmap_pkg::CLAMP_W;
    localparam int FSW = scmap_pkg::FS_W;
    localparam int PW  = scmap_pkg::PROD_W;
    localparam int NW  = scmap_pkg::STAT_N_W;
    localparam int MW  = scmap_pkg::STAT_NUM_W;
    localparam int QW  = scmap_pkg::STAT_Q_W;
    localparam int CW  = scmap_pkg::CH_W;
    localparam int SW  = scmap_pkg::SEL_W;
    localparam int NP_W = PW + 1 - 16;

    localparam logic signed [WW-1:0] X_ONE     = WW'(scmap_pkg::ONE_Q);
    localparam logic signed [WW-1:0] X_NEG_ONE = -WW'(scmap_pkg::ONE_Q);
    localparam logic signed [WW-1:0] X_RED     = WW'(scmap_pkg::STAT_RED_LIM);
    localparam logic signed [WW-1:0] X_ORANGE  = WW'(scmap_pkg::STAT_ORANGE_LIM);
    localparam logic signed [WW-1:0] X_BLEND   = WW'(scmap_pkg::STAT_BLEND_LIM);

    typedef enum logic [2:0] {
        ST_INVALID,
        ST_RED,
        ST_ORANGE,
        ST_WHITE,
        ST_BLEND,
        ST_RAMP
    } stat_class_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [SW-1:0] map_select_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == scmap_pkg::REG_MAP_SELECT);
    assign prdata    = (paddr[2] == scmap_pkg::REG_MAP_SELECT)
                       ? {{(scmap_pkg::APB_DW-SW){1'b0}}, map_select_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_select_reg <= scmap_pkg::MAP_GREY;
        end
        else if (cfg_write)
        begin
            map_select_reg <= pwdata[SW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or when the
    // stage after it loads, so bubbles are squeezed out under a stall.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic ld1, ld2, ld3, ld4, ld_out;

    assign ld_out       = !out_valid_reg || !color_stall;
    assign ld4          = !s4_valid_reg || ld_out;
    assign ld3          = !s3_valid_reg || ld4;
    assign ld2          = !s2_valid_reg || ld3;
    assign ld1          = !s1_valid_reg || ld2;
    assign sample_stall = !ld1;
    assign color_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (ld2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ld3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ld4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (ld_out)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic signed [VW-1:0] s1_value_reg;
    logic                 s1_bad_reg;
    logic [SW-1:0]        s1_sel_reg;

    // ------------------------------------------------------------------
    // Stage A: clamps, 1/pi multiply, status classification
    // ------------------------------------------------------------------
    logic signed [WW-1:0] xw;
    logic [VW-1:0]        ax;
    logic [CLW-1:0]       s2_cl01_next;
    logic [FSW-1:0]       s2_fs_n_next;
    logic                 s2_fs_zero_next;
    logic [PW-1:0]        s2_prod_next;
    stat_class_t          s2_class_next;
    logic [NW-1:0]        s2_stat_n_next;
    logic [19:0]          blend_n_wide;
    logic [19:0]          ramp_n_wide;
    logic signed [WW-1:0] fs_sum;

    assign xw = $signed({{(WW-VW){s1_value_reg[VW-1]}}, s1_value_reg});
    assign ax = s1_value_reg[VW-1] ? VW'(-s1_value_reg) : VW'(s1_value_reg);

    always_comb
    begin
        if (xw < 0)
        begin
            s2_cl01_next = '0;
        end
        else if (xw > X_ONE)
        begin
            s2_cl01_next = CLW'(scmap_pkg::ONE_Q);
        end
        else
        begin
            s2_cl01_next = xw[CLW-1:0];
        end

        if (xw < X_NEG_ONE)
        begin
            fs_sum = '0;
        end
        else if (xw > X_ONE)
        begin
            fs_sum = X_ONE + X_ONE;
        end
        else
        begin
            fs_sum = xw + X_ONE;
        end
        s2_fs_n_next    = fs_sum[FSW-1:0];
        s2_fs_zero_next = (xw == 0);
        s2_prod_next    = PW'(ax) * PW'(scmap_pkg::INV_PI_Q16);

        if (s2_fs_zero_next || s1_bad_reg)
        begin
            s2_class_next = ST_INVALID;
        end
        else if (xw < X_RED)
        begin
            s2_class_next = ST_RED;
        end
        else if (xw >= X_ORANGE)
        begin
            s2_class_next = ST_ORANGE;
        end
        else if (xw >= X_ONE)
        begin
            s2_class_next = ST_WHITE;
        end
        else if (xw >= X_BLEND)
        begin
            s2_class_next = ST_BLEND;
        end
        else
        begin
            s2_class_next = ST_RAMP;
        end

        // Within the blend and ramp bands the clamped value equals v itself.
        blend_n_wide = 20'(s2_cl01_next) * 20'd100 - 20'(scmap_pkg::BLEND_OFS);
        ramp_n_wide  = 20'(s2_cl01_next) * 20'd10 - 20'(scmap_pkg::RAMP_OFS);
        s2_stat_n_next = (s2_class_next == ST_BLEND) ? blend_n_wide[NW-1:0]
                                                     : ramp_n_wide[NW-1:0];
    end

    logic [SW-1:0]  s2_sel_reg;
    logic [CLW-1:0] s2_cl01_reg;
    logic [FSW-1:0] s2_fs_n_reg;
    logic           s2_fs_zero_reg;
    logic [PW-1:0]  s2_prod_reg;
    stat_class_t    s2_class_reg;
    logic [NW-1:0]  s2_stat_n_reg;

    // ------------------------------------------------------------------
    // Stage B: linear channels, rainbow position, status numerators
    // ------------------------------------------------------------------
    logic [CW-1:0]   s3_lin_next;
    logic [CW-1:0]   s3_fsc_next;
    logic [FSW-1:0]  s3_t_next;
    logic [QW-1:0]   s3_q_next [3];
    logic [20:0]     lin_sum;
    logic [21:0]     fsc_sum;
    logic [PW:0]     np_sum;
    logic [NP_W-1:0] np;
    logic [CLW-1:0]  np_cl;
    logic [FSW-1:0]  hue_n;
    logic [3:0]      base;
    logic [11:0]     k_mul;
    logic [MW-1:0]   c0;
    logic [MW-1:0]   num;
    logic            s2_blend;

    assign s2_blend = (s2_class_reg == ST_BLEND);

    always_comb
    begin
        lin_sum     = 21'(s2_cl01_reg) * 21'd255 + 21'(scmap_pkg::ONE_Q / 2);
        s3_lin_next = lin_sum[scmap_pkg::FRAC_W +: CW];
        fsc_sum     = 22'(s2_fs_n_reg) * 22'd255 + 22'(scmap_pkg::ONE_Q);
        s3_fsc_next = fsc_sum[scmap_pkg::FRAC_W+1 +: CW];

        np_sum = (PW+1)'(s2_prod_reg) + (PW+1)'(32768);
        np     = np_sum[PW:16];
        np_cl  = (np > NP_W'(scmap_pkg::ONE_Q)) ? CLW'(scmap_pkg::ONE_Q)
                                                : np[CLW-1:0];

        // Everything runs on a denominator of 2*ONE_Q.
        case (s2_sel_reg)
            scmap_pkg::MAP_RAINBOW_FS: hue_n = s2_fs_n_reg;
            scmap_pkg::MAP_PHASE:      hue_n = {np_cl, 1'b0};
            default:                   hue_n = {s2_cl01_reg, 1'b0};
        endcase
        s3_t_next = FSW'(2 * scmap_pkg::ONE_Q) - hue_n;

        base  = '0;
        k_mul = '0;
        c0    = '0;
        num   = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            base = scmap_pkg::status_base(s2_sel_reg[1:0], 2'(ch));
            if (s2_blend)
            begin
                k_mul = 12'(4'd10 - base) * 12'd255;
                c0    = MW'(base) * MW'(255 * scmap_pkg::BLEND_SCALE)
                        + MW'(scmap_pkg::BLEND_ROUND);
                num   = MW'(k_mul) * MW'(s2_stat_n_reg) + c0;
                s3_q_next[ch] = QW'(num >> scmap_pkg::BLEND_SHIFT);
            end
            else
            begin
                k_mul = 12'(base) * 12'd255;
                c0    = MW'(scmap_pkg::RAMP_ROUND);
                num   = MW'(k_mul) * MW'(s2_stat_n_reg) + c0;
                s3_q_next[ch] = QW'(num >> scmap_pkg::RAMP_SHIFT);
            end
        end
    end

    logic [SW-1:0]  s3_sel_reg;
    stat_class_t    s3_class_reg;
    logic           s3_fs_zero_reg;
    logic [CW-1:0]  s3_lin_reg;
    logic [CW-1:0]  s3_fsc_reg;
    logic [FSW-1:0] s3_t_reg;
    logic [QW-1:0]  s3_q_reg [3];

    // ------------------------------------------------------------------
    // Stage C: hue sector and fraction, status division by reciprocal
    // ------------------------------------------------------------------
    logic [2:0]       s4_sec_next;
    logic [CW-1:0]    s4_f_next;
    logic [CW-1:0]    s4_nf_next;
    logic [CW-1:0]    s4_sc_next [3];
    logic [FSW-2:0]   rem;
    logic [21:0]      f_sum;
    logic [21:0]      nf_sum;
    logic [MW-1:0]    rq;
    logic [CW:0]      rq_q;

    always_comb
    begin
        // w = 4*t; sector = w / (2*ONE_Q), remainder in the low bits.
        s4_sec_next = s3_t_reg[FSW-1 -: 3];
        rem         = {s3_t_reg[FSW-4:0], 2'b00};
        f_sum       = 22'(rem) * 22'd255 + 22'(scmap_pkg::ONE_Q);
        nf_sum      = (22'(2 * scmap_pkg::ONE_Q) - 22'(rem)) * 22'd255
                      + 22'(scmap_pkg::ONE_Q);
        s4_f_next   = f_sum[scmap_pkg::FRAC_W+1 +: CW];
        s4_nf_next  = nf_sum[scmap_pkg::FRAC_W+1 +: CW];

        rq   = '0;
        rq_q = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (s3_class_reg == ST_BLEND)
            begin
                rq   = MW'(s3_q_reg[ch]) * MW'(scmap_pkg::RECIP15);
                rq_q = (CW+1)'(rq >> scmap_pkg::RECIP15_SHIFT);
            end
            else
            begin
                rq   = MW'(s3_q_reg[ch]) * MW'(scmap_pkg::RECIP35);
                rq_q = (CW+1)'(rq >> scmap_pkg::RECIP35_SHIFT);
            end
            s4_sc_next[ch] = rq_q[CW] ? scmap_pkg::CH_FULL : rq_q[CW-1:0];
        end
    end

    logic [SW-1:0] s4_sel_reg;
    stat_class_t   s4_class_reg;
    logic          s4_fs_zero_reg;
    logic [CW-1:0] s4_lin_reg;
    logic [CW-1:0] s4_fsc_reg;
    logic [2:0]    s4_sec_reg;
    logic [CW-1:0] s4_f_reg;
    logic [CW-1:0] s4_nf_reg;
    logic [CW-1:0] s4_sc_reg [3];

    // ------------------------------------------------------------------
    // Stage D: select the color for the map
    // ------------------------------------------------------------------
    scmap_pkg::color_t rainbow_col;
    scmap_pkg::color_t status_col;
    scmap_pkg::color_t color_next;
    scmap_pkg::color_t color_reg;

    always_comb
    begin
        rainbow_col.alpha = scmap_pkg::CH_FULL;
        case (s4_sec_reg)
            3'd0:
            begin
                rainbow_col.red   = scmap_pkg::CH_FULL;
                rainbow_col.green = s4_f_reg;
                rainbow_col.blue  = scmap_pkg::CH_ZERO;
            end
            3'd1:
            begin
                rainbow_col.red   = s4_nf_reg;
                rainbow_col.green = scmap_pkg::CH_FULL;
                rainbow_col.blue  = scmap_pkg::CH_ZERO;
            end
            3'd2:
            begin
                rainbow_col.red   = scmap_pkg::CH_ZERO;
                rainbow_col.green = scmap_pkg::CH_FULL;
                rainbow_col.blue  = s4_f_reg;
            end
            3'd3:
            begin
                rainbow_col.red   = scmap_pkg::CH_ZERO;
                rainbow_col.green = s4_nf_reg;
                rainbow_col.blue  = scmap_pkg::CH_FULL;
            end
            default:
            begin
                rainbow_col.red   = s4_f_reg;
                rainbow_col.green = scmap_pkg::CH_ZERO;
                rainbow_col.blue  = scmap_pkg::CH_FULL;
            end
        endcase

        status_col.alpha = scmap_pkg::CH_FULL;
        case (s4_class_reg)
            ST_INVALID:
            begin
                status_col.red   = scmap_pkg::CH_INVALID;
                status_col.green = scmap_pkg::CH_INVALID;
                status_col.blue  = scmap_pkg::CH_INVALID;
                status_col.alpha = scmap_pkg::ALPHA_INV;
            end
            ST_RED:
            begin
                status_col.red   = scmap_pkg::CH_FULL;
                status_col.green = scmap_pkg::CH_ZERO;
                status_col.blue  = scmap_pkg::CH_ZERO;
            end
            ST_ORANGE:
            begin
                status_col.red   = scmap_pkg::CH_FULL;
                status_col.green = scmap_pkg::CH_ORANGE;
                status_col.blue  = scmap_pkg::CH_ZERO;
            end
            ST_WHITE:
            begin
                status_col.red   = scmap_pkg::CH_FULL;
                status_col.green = scmap_pkg::CH_FULL;
                status_col.blue  = scmap_pkg::CH_FULL;
            end
            default:
            begin
                status_col.red   = s4_sc_reg[0];
                status_col.green = s4_sc_reg[1];
                status_col.blue  = s4_sc_reg[2];
            end
        endcase

        color_next.alpha = scmap_pkg::CH_FULL;
        color_next.red   = s4_lin_reg;
        color_next.green = s4_lin_reg;
        color_next.blue  = s4_lin_reg;
        if (s4_sel_reg inside {[scmap_pkg::MAP_STATUS_BLUE:scmap_pkg::MAP_STATUS_GREEN]})
        begin
            color_next = status_col;
        end
        else
        begin
            case (s4_sel_reg)
                scmap_pkg::MAP_GREY_FS:
                begin
                    color_next.red   = s4_fs_zero_reg ? scmap_pkg::CH_ZERO : s4_fsc_reg;
                    color_next.green = s4_fs_zero_reg ? scmap_pkg::CH_ZERO : s4_fsc_reg;
                    color_next.blue  = s4_fs_zero_reg ? scmap_pkg::CH_ZERO : s4_fsc_reg;
                end
                scmap_pkg::MAP_RED:
                begin
                    color_next.green = scmap_pkg::CH_ZERO;
                    color_next.blue  = scmap_pkg::CH_ZERO;
                end
                scmap_pkg::MAP_GREEN:
                begin
                    color_next.red  = scmap_pkg::CH_ZERO;
                    color_next.blue = scmap_pkg::CH_ZERO;
                end
                scmap_pkg::MAP_BLUE:
                begin
                    color_next.red   = scmap_pkg::CH_ZERO;
                    color_next.green = scmap_pkg::CH_ZERO;
                end
                scmap_pkg::MAP_RAINBOW, scmap_pkg::MAP_PHASE:
                begin
                    color_next = rainbow_col;
                end
                scmap_pkg::MAP_RAINBOW_FS:
                begin
                    // Zero on the full-scale rainbow is opaque black.
                    if (s4_fs_zero_reg)
                    begin
                        color_next.red   = scmap_pkg::CH_ZERO;
                        color_next.green = scmap_pkg::CH_ZERO;
                        color_next.blue  = scmap_pkg::CH_ZERO;
                    end
                    else
                    begin
                        color_next = rainbow_col;
                    end
                end
                default:
                begin
                    color_next.red = s4_lin_reg;
                end
            endcase
        end
    end

    assign color = color_reg;

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_value_reg <= sample.value;
            s1_bad_reg   <= sample.value_not_finite;
            s1_sel_reg   <= map_select_reg;
        end
        if (ld2)
        begin
            s2_sel_reg     <= s1_sel_reg;
            s2_cl01_reg    <= s2_cl01_next;
            s2_fs_n_reg    <= s2_fs_n_next;
            s2_fs_zero_reg <= s2_fs_zero_next;
            s2_prod_reg    <= s2_prod_next;
            s2_class_reg   <= s2_class_next;
            s2_stat_n_reg  <= s2_stat_n_next;
        end
        if (ld3)
        begin
            s3_sel_reg     <= s2_sel_reg;
            s3_class_reg   <= s2_class_reg;
            s3_fs_zero_reg <= s2_fs_zero_reg;
            s3_lin_reg     <= s3_lin_next;
            s3_fsc_reg     <= s3_fsc_next;
            s3_t_reg       <= s3_t_next;
            s3_q_reg       <= s3_q_next;
        end
        if (ld4)
        begin
            s4_sel_reg     <= s3_sel_reg;
            s4_class_reg   <= s3_class_reg;
            s4_fs_zero_reg <= s3_fs_zero_reg;
            s4_lin_reg     <= s3_lin_reg;
            s4_fsc_reg     <= s3_fsc_reg;
            s4_sec_reg     <= s4_sec_next;
            s4_f_reg       <= s4_f_next;
            s4_nf_reg      <= s4_nf_next;
            s4_sc_reg      <= s4_sc_next;
        end
        if (ld_out)
        begin
            color_reg <= color_next;
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for scalar_to_rgba_color_map_core: predicts each color
// from the sample and map_select and compares it with the output stream.
// Depends on scmap_pkg and the core RTL.
module testbench;

    localparam int PIPE_LATENCY   = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_MAP  = 10;
    localparam int MAP_CODES      = 16;

    localparam logic [scmap_pkg::APB_AW-1:0] ADDR_MAP_SELECT = 3'd0;
    // Address of a register slot that does not exist; writes there are ignored.
    localparam logic [scmap_pkg::APB_AW-1:0] ADDR_UNUSED     = 3'd4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    scmap_pkg::sample_t            sample = '0;
    logic                          color_valid;
    logic                          color_stall = 1'b0;
    scmap_pkg::color_t             color;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [scmap_pkg::APB_AW-1:0]  paddr = '0;
    logic [scmap_pkg::APB_DW-1:0]  pwdata = '0;
    logic [scmap_pkg::APB_DW-1:0]  prdata;
    logic                          pready;

    scmap_pkg::sample_t                   pending_samples[$];
    scmap_pkg::color_t                    expected_colors[$];
    logic signed [scmap_pkg::VALUE_W-1:0] corner_values[$];

    logic [scmap_pkg::SEL_W-1:0] cur_map = scmap_pkg::MAP_GREY;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;

    scalar_to_rgba_color_map_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .color_valid  (color_valid),
        .color_stall  (color_stall),
        .color        (color),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [scmap_pkg::CH_W-1:0] to_channel(input longint x);
        if (x < 0)
            return scmap_pkg::CH_ZERO;
        if (x > 255)
            return scmap_pkg::CH_FULL;
        return scmap_pkg::CH_W'(x);
    endfunction

    function automatic scmap_pkg::color_t pack_color(input longint r, input longint g,
                                                     input longint b, input longint a);
        scmap_pkg::color_t c;
        c.red   = to_channel(r);
        c.green = to_channel(g);
        c.blue  = to_channel(b);
        c.alpha = to_channel(a);
        return c;
    endfunction

    function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Hue 240*(1 - n/d) at full saturation and value, with n in [0, d].
    function automatic scmap_pkg::color_t hue_color(input longint n, input longint d);
        longint w, sector, rem, f, nf;
        w = 4 * (d - n);
        sector = w / d;
        rem = w % d;
        f = (rem * 255 + d / 2) / d;
        nf = ((d - rem) * 255 + d / 2) / d;
        case (sector)
            0: return pack_color(255, f, 0, 255);
            1: return pack_color(nf, 255, 0, 255);
            2: return pack_color(0, 255, f, 255);
            3: return pack_color(0, nf, 255, 255);
            default: return pack_color(f, 0, 255, 255);
        endcase
    endfunction

    function automatic scmap_pkg::color_t status_color(input longint x, input logic bad,
                                                       input logic [1:0] which);
        longint tenths[3];
        longint chan[3];
        longint n;
        case (which)
            2'd0:
            begin
                tenths[0] = 0; tenths[1] = 0; tenths[2] = 10;
            end
            2'd1:
            begin
                tenths[0] = 0; tenths[1] = 10; tenths[2] = 10;
            end
            2'd2:
            begin
                tenths[0] = 7; tenths[1] = 0; tenths[2] = 7;
            end
            default:
            begin
                tenths[0] = 0; tenths[1] = 10; tenths[2] = 0;
            end
        endcase
        if (x == 0 || bad)
            return pack_color(longint'(scmap_pkg::CH_INVALID),
                              longint'(scmap_pkg::CH_INVALID),
                              longint'(scmap_pkg::CH_INVALID),
                              longint'(scmap_pkg::ALPHA_INV));
        if (x * 10 < 3 * scmap_pkg::ONE_Q)
            return pack_color(255, 0, 0, 255);
        if (x * 10 >= 12 * scmap_pkg::ONE_Q)
            return pack_color(255, longint'(scmap_pkg::CH_ORANGE), 0, 255);
        if (x * 20 > 19 * scmap_pkg::ONE_Q && x < scmap_pkg::ONE_Q)
        begin
            // Blend toward white over (v - 0.95) / 0.06.
            n = 100 * x - 95 * scmap_pkg::ONE_Q;
            for (int i = 0; i < 3; i++)
                chan[i] = (255 * (tenths[i] * 6 * scmap_pkg::ONE_Q + n * (10 - tenths[i]))
                           + 30 * scmap_pkg::ONE_Q) / (60 * scmap_pkg::ONE_Q);
            return pack_color(chan[0], chan[1], chan[2], 255);
        end
        if (x >= scmap_pkg::ONE_Q)
            return pack_color(255, 255, 255, 255);
        n = 10 * x - 3 * scmap_pkg::ONE_Q;
        for (int i = 0; i < 3; i++)
            chan[i] = (255 * tenths[i] * n + 35 * scmap_pkg::ONE_Q)
                      / (70 * scmap_pkg::ONE_Q);
        return pack_color(chan[0], chan[1], chan[2], 255);
    endfunction

    function automatic scmap_pkg::color_t map_scalar(input scmap_pkg::sample_t s,
                                                     input logic [scmap_pkg::SEL_W-1:0] sel);
        longint x, c, ax, n;
        x = longint'(s.value);
        case (sel)
            scmap_pkg::MAP_GREY_FS:
            begin
                c = clamp_to(x, -scmap_pkg::ONE_Q, scmap_pkg::ONE_Q);
                if (c == 0)
                    return pack_color(0, 0, 0, 255);
                c = ((c + scmap_pkg::ONE_Q) * 255 + scmap_pkg::ONE_Q) / (2 * scmap_pkg::ONE_Q);
                return pack_color(c, c, c, 255);
            end
            scmap_pkg::MAP_RED, scmap_pkg::MAP_GREEN, scmap_pkg::MAP_BLUE:
            begin
                c = (clamp_to(x, 0, scmap_pkg::ONE_Q) * 255 + scmap_pkg::ONE_Q / 2)
                    / scmap_pkg::ONE_Q;
                return pack_color(sel == scmap_pkg::MAP_RED ? c : 0,
                                  sel == scmap_pkg::MAP_GREEN ? c : 0,
                                  sel == scmap_pkg::MAP_BLUE ? c : 0, 255);
            end
            scmap_pkg::MAP_RAINBOW:
                return hue_color(clamp_to(x, 0, scmap_pkg::ONE_Q), scmap_pkg::ONE_Q);
            scmap_pkg::MAP_RAINBOW_FS:
            begin
                c = clamp_to(x, -scmap_pkg::ONE_Q, scmap_pkg::ONE_Q);
                if (c == 0)
                    return pack_color(0, 0, 0, 255);
                return hue_color(c + scmap_pkg::ONE_Q, 2 * scmap_pkg::ONE_Q);
            end
            scmap_pkg::MAP_PHASE:
            begin
                ax = (x < 0) ? -x : x;
                n = (ax * scmap_pkg::INV_PI_Q16 + 32768) / 65536;
                return hue_color(clamp_to(n, 0, scmap_pkg::ONE_Q), scmap_pkg::ONE_Q);
            end
            scmap_pkg::MAP_STATUS_BLUE, scmap_pkg::MAP_STATUS_CYAN,
            scmap_pkg::MAP_STATUS_PURPLE, scmap_pkg::MAP_STATUS_GREEN:
                return status_color(x, s.value_not_finite, sel[1:0]);
            default:
            begin
                // Grey, and the unused codes above the status maps.
                c = (clamp_to(x, 0, scmap_pkg::ONE_Q) * 255 + scmap_pkg::ONE_Q / 2)
                    / scmap_pkg::ONE_Q;
                return pack_color(c, c, c, 255);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("ERROR at %0t: %s expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Sample driver: a transaction is accepted at an edge with valid high and
    // stall low; the payload holds while stalled.
    always @(posedge clk)
    begin : sample_driver
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                expected_colors.push_back(map_scalar(sample, cur_map));
            if (!sample_valid || !sample_stall)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : color_monitor
        scmap_pkg::color_t want;
        if (rst_n)
        begin
            if (color_valid && !color_stall)
            begin
                if (expected_colors.size() == 0)
                    report_mismatch("unexpected color transaction", 0, 1);
                else
                begin
                    want = expected_colors.pop_front();
                    if (color.red !== want.red)
                        report_mismatch("red", 32'(want.red), 32'(color.red));
                    if (color.green !== want.green)
                        report_mismatch("green", 32'(want.green), 32'(color.green));
                    if (color.blue !== want.blue)
                        report_mismatch("blue", 32'(want.blue), 32'(color.blue));
                    if (color.alpha !== want.alpha)
                        report_mismatch("alpha", 32'(want.alpha), 32'(color.alpha));
                end
            end
            color_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((sample_valid && !sample_stall) || (color_valid && !color_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("scalar_to_rgba_color_map_core: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic write_register(input logic [scmap_pkg::APB_AW-1:0] addr,
                                  input logic [scmap_pkg::APB_DW-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[2] == scmap_pkg::REG_MAP_SELECT)
            cur_map = data[scmap_pkg::SEL_W-1:0];
    endtask

    task automatic check_map_readback();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_MAP_SELECT;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== scmap_pkg::APB_DW'(cur_map))
            report_mismatch("map_select readback", scmap_pkg::APB_DW'(cur_map), prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Holds off until the pipeline is empty, then lets it settle.
    task automatic wait_until_drained();
        while (pending_samples.size() > 0 || sample_valid || expected_colors.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 3) @(posedge clk);
    endtask

    function automatic scmap_pkg::sample_t random_sample();
        scmap_pkg::sample_t s;
        case ($urandom_range(9))
            0, 1, 2: s.value = corner_values[$urandom_range(corner_values.size() - 1)];
            3, 4, 5: s.value = scmap_pkg::VALUE_W'($urandom_range(6 * scmap_pkg::ONE_Q / 2)
                                                   - 3 * scmap_pkg::ONE_Q / 2);
            default: s.value = scmap_pkg::VALUE_W'($urandom);
        endcase
        s.value_not_finite = ($urandom_range(3) == 0);
        return s;
    endfunction

    initial
    begin : stimulus
        scmap_pkg::sample_t s;
        logic [scmap_pkg::APB_DW-1:0] data;
        int unsigned count;

        // Range ends, clamp edges, hue sector edges, status thresholds and the
        // point where |v|/pi saturates.
        corner_values = '{-32768, 32767, -4097, -4096, -2048, -1, 0, 1, 1024, 2048,
                          3072, 4095, 4096, 4097, 1228, 1229, 3891, 3892, 3900,
                          4915, 4916, 12867, 12868, -12868};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        check_map_readback();

        // Directed: upper data bits are dropped, and the empty slot is ignored.
        write_register(ADDR_MAP_SELECT, {28'hFFFFFFF, scmap_pkg::MAP_STATUS_PURPLE});
        write_register(ADDR_UNUSED, {28'd0, scmap_pkg::MAP_GREY});
        check_map_readback();
        foreach (corner_values[i])
        begin
            s.value = corner_values[i];
            s.value_not_finite = 1'b0;
            pending_samples.push_back(s);
        end
        s.value = 16'sd2048;
        s.value_not_finite = 1'b1;
        pending_samples.push_back(s);
        wait_until_drained();

        for (int regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:
                begin
                    send_idle_pct = 9;
                    recv_idle_pct = 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_idle_pct = 9;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int m = 0; m < MAP_CODES; m++)
            begin
                data = $urandom;
                data[scmap_pkg::SEL_W-1:0] = scmap_pkg::SEL_W'(m);
                write_register(ADDR_MAP_SELECT, data);
                if ($urandom_range(3) == 0)
                    write_register(ADDR_UNUSED, $urandom);
                check_map_readback();
                count = ITEMS_PER_MAP + $urandom_range(3);
                repeat (count) pending_samples.push_back(random_sample());
                wait_until_drained();
            end
        end

        if (mismatches == 0)
            $display("scalar_to_rgba_color_map_core: match");
        else
            $display("scalar_to_rgba_color_map_core: mismatch");
        $finish;
    end

endmodule
